### src/sdot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdot_pkg: shared types and constants
// Field widths, status codes, register indexes and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package sdot_pkg;

	// field widths
	localparam int CLS_W      = 6;
	localparam int HOUR_W     = 8;
	localparam int POS_W      = 24;
	localparam int MASK_W     = 64;
	localparam int TOL_W      = 49;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;
	localparam int STATUS_W   = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CLASS_MASK = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOL_SQ     = 4'd1;

	// reset value of the squared tolerance: (2.0)^2 in 16 fraction bits
	localparam logic [TOL_W-1:0] TOL_RESET = 49'd262144;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_CLASS_OFF = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	// one stored object
	typedef struct packed {
		logic [CLS_W-1:0]         cls;
		logic [HOUR_W-1:0]        hour;
		logic signed [POS_W-1:0]  x;
		logic signed [POS_W-1:0]  y;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture request, clear scan pointer and duplicate flag
		logic rd;      // read entry at scan pointer, advance pointer
		logic commit;  // decide, append if allowed, present result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic class_ok;
		logic count_zero;
		logic scan_last;
		logic busy;      // compare pipeline still holds reads
		logic out_full;  // result register still occupied
	} stat_t;

endpackage

### src/sdot_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdot_if: channel interfaces
// Configuration write channel, object request channel and result channel,
// each with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface sdot_cfg_if;
	import sdot_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

interface sdot_obj_if;
	import sdot_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [CLS_W-1:0]        class_id;
	logic [HOUR_W-1:0]       hour_slot;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	modport source (output valid, output class_id, output hour_slot, output pos_x,
		output pos_y, input ready);
	modport sink   (input valid, input class_id, input hour_slot, input pos_x,
		input pos_y, output ready);
endinterface

interface sdot_res_if #(parameter int CNT_W = 9);
	import sdot_pkg::*;
	logic                valid;
	logic                ready;
	logic                inserted;
	logic [STATUS_W-1:0] status;
	logic [CNT_W-1:0]    entries_held;
	modport source (output valid, output inserted, output status,
		output entries_held, input ready);
	modport sink   (input valid, input inserted, input status,
		input entries_held, output ready);
endinterface

### src/sdot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdot_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sdot_ram #(
	parameter int WIDTH = 62,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### src/sdot_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdot_datapath: object store, distance pipeline and result register
// Holds the config registers, the captured request, the entry store, a
// four-stage compare pipeline fed by the store's read port, the entry count
// and the result register.
// ----------------------------------------------------------------------------
module sdot_datapath import sdot_pkg::*; #(
	parameter int STORE_DEPTH = 256,
	parameter int CLASS_COUNT = 64,
	parameter int CNT_W       = 9
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	// request payload
	input  logic [CLS_W-1:0]        in_class_id,
	input  logic [HOUR_W-1:0]       in_hour_slot,
	input  logic signed [POS_W-1:0] in_pos_x,
	input  logic signed [POS_W-1:0] in_pos_y,
	// control
	input  cmd_t                    cmd,
	output stat_t                   stat,
	// result
	output logic                    res_valid,
	input  logic                    res_ready,
	output logic                    res_inserted,
	output logic [STATUS_W-1:0]     res_status,
	output logic [CNT_W-1:0]        res_entries_held
);
	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);

	// configuration registers
	logic [CLASS_COUNT-1:0] mask_q;
	logic [TOL_W-1:0]       tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			tol_q  <= TOL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLASS_MASK: mask_q <= cfg_data[CLASS_COUNT-1:0];
				CFG_TOL_SQ:     tol_q  <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// captured request
	entry_t item_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q.cls  <= in_class_id;
			item_q.hour <= in_hour_slot;
			item_q.x    <= in_pos_x;
			item_q.y    <= in_pos_y;
		end
	end

	// class filter; classes at or above CLASS_COUNT see zero mask bits
	logic [MASK_W-1:0] mask_ext;
	assign mask_ext = MASK_W'(mask_q);

	// entry count and scan pointer
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_addr_q;
	logic             full;
	logic             insert_now;
	logic             dup_q;

	assign full       = (count_q == DEPTH_C);
	assign insert_now = cmd.commit && mask_ext[item_q.cls] && !dup_q && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			scan_addr_q <= '0;
		end else begin
			if (cmd.load) begin
				scan_addr_q <= '0;
			end else if (cmd.rd) begin
				scan_addr_q <= scan_addr_q + 1'b1;
			end
			if (insert_now) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// entry store
	entry_t rd_entry;
	logic [ENTRY_W-1:0] rd_bits;

	sdot_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (insert_now),
		.waddr (count_q[AW-1:0]),
		.wdata (item_q),
		.re    (cmd.rd),
		.raddr (scan_addr_q[AW-1:0]),
		.rdata (rd_bits)
	);

	assign rd_entry = entry_t'(rd_bits);

	// compare pipeline: s1 read data, s2 differences, s3 squares, then accumulate
	logic v_s1, v_s2, v_s3;
	logic eq_s2, eq_s3;
	logic signed [POS_W:0] dx_s2, dy_s2;
	logic [TOL_W-1:0] sqx_s3, sqy_s3;
	logic signed [2*POS_W+1:0] prod_x, prod_y;
	logic [TOL_W:0] dist_sq;

	assign prod_x  = dx_s2 * dx_s2;
	assign prod_y  = dy_s2 * dy_s2;
	assign dist_sq = {1'b0, sqx_s3} + {1'b0, sqy_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			dup_q <= 1'b0;
		end else begin
			v_s1 <= cmd.rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.load) begin
				dup_q <= 1'b0;
			end else if (v_s3 && eq_s3 && (dist_sq <= {1'b0, tol_q})) begin
				dup_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		eq_s2  <= (rd_entry.cls == item_q.cls) && (rd_entry.hour == item_q.hour);
		dx_s2  <= (POS_W+1)'(rd_entry.x) - (POS_W+1)'(item_q.x);
		dy_s2  <= (POS_W+1)'(rd_entry.y) - (POS_W+1)'(item_q.y);
		eq_s3  <= eq_s2;
		sqx_s3 <= prod_x[TOL_W-1:0];
		sqy_s3 <= prod_y[TOL_W-1:0];
	end

	// result register
	logic                out_valid_q;
	logic                out_ins_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [CNT_W-1:0]    out_count_q;
	logic [STATUS_W-1:0] status_now;

	always_comb begin
		if (!mask_ext[item_q.cls]) begin
			status_now = ST_CLASS_OFF;
		end else if (dup_q) begin
			status_now = ST_DUPLICATE;
		end else if (full) begin
			status_now = ST_FULL;
		end else begin
			status_now = ST_INSERTED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_ins_q    <= insert_now;
			out_status_q <= status_now;
			out_count_q  <= insert_now ? count_q + 1'b1 : count_q;
		end
	end

	assign res_valid        = out_valid_q;
	assign res_inserted     = out_ins_q;
	assign res_status       = out_status_q;
	assign res_entries_held = out_count_q;

	// status to controller
	assign stat.class_ok   = mask_ext[item_q.cls];
	assign stat.count_zero = (count_q == '0);
	assign stat.scan_last  = (scan_addr_q == count_q - 1'b1);
	assign stat.busy       = v_s1 || v_s2 || v_s3;
	assign stat.out_full   = out_valid_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count beyond store depth");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> scan_addr_q < count_q)
		else $error("scan read past held entries");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		insert_now |=> count_q == $past(count_q) + 1'b1)
		else $error("append did not advance count");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !out_valid_q)
		else $error("commit while result register occupied");

	a_commit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(v_s1 || v_s2 || v_s3))
		else $error("commit with compares in flight");
endmodule

### src/sdot_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdot_ctrl: request sequencer
// Accepts a request, scans the held entries one read a cycle, waits for the
// compare pipeline to drain, then commits the decision.
// ----------------------------------------------------------------------------
module sdot_ctrl import sdot_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_DECIDE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.rd     = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!stat.class_ok || stat.count_zero) begin
					state_d = S_DECIDE;
				end else begin
					cmd.rd = 1'b1;
					if (stat.scan_last) begin
						state_d = S_DRAIN;
					end
				end
			end
			S_DRAIN: begin
				if (!stat.busy) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!stat.out_full) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// checks
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == S_IDLE)
		else $error("request captured outside idle");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.rd, cmd.commit}))
		else $error("overlapping datapath commands");

	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> state_q == S_IDLE)
		else $error("sequencer did not return to idle after commit");
endmodule

### src/spatial_dedup_object_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spatial_dedup_object_table: class-filtered spatial duplicate filter
// Top level joining the request sequencer and the store datapath.
// ----------------------------------------------------------------------------
// One object request is handled at a time. A request holds the sequencer
// through the accepting cycle, one scan read for each entry held, a drain
// for the read latency and the three compare stages, and a commit cycle.
// The result register loads at the end of the commit cycle. A request
// whose class is not allowed, or that meets an empty store, skips the scan
// and drain. The time a request takes is set by the scan of the entry
// store through its single read port, one entry a cycle. The result sits in
// an output register, so the next request is accepted while it waits; only
// its commit waits for the register to empty. A squared distance equal to
// the squared tolerance counts as a duplicate. Configuration writes are
// always accepted and are meant for idle times.
// ----------------------------------------------------------------------------
module spatial_dedup_object_table import sdot_pkg::*; #(
	parameter int STORE_DEPTH = 256,
	parameter int CLASS_COUNT = 64,
	parameter int CNT_W       = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	sdot_cfg_if.sink      cfg,
	sdot_obj_if.sink      obj,
	sdot_res_if.source    res
);
	cmd_t  cmd;
	stat_t stat;
	logic  cfg_we;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid;

	sdot_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (obj.valid),
		.in_ready (obj.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sdot_datapath #(
		.STORE_DEPTH (STORE_DEPTH),
		.CLASS_COUNT (CLASS_COUNT),
		.CNT_W       (CNT_W)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg.index),
		.cfg_data         (cfg.data),
		.in_class_id      (obj.class_id),
		.in_hour_slot     (obj.hour_slot),
		.in_pos_x         (obj.pos_x),
		.in_pos_y         (obj.pos_y),
		.cmd              (cmd),
		.stat             (stat),
		.res_valid        (res.valid),
		.res_ready        (res.ready),
		.res_inserted     (res.inserted),
		.res_status       (res.status),
		.res_entries_held (res.entries_held)
	);
endmodule
